FILE: hw/rtl/mbe_pkg.sv
// Shared types, constants and helpers for the escape-time evaluator.
`default_nettype none
package mbe_pkg;

    localparam int CFG_W  = 32;
    localparam int Z_W    = 36;
    localparam int PROD_W = 64;
    localparam int FRAC   = 28;
    localparam int COORD_W = 8;

    typedef logic signed [Z_W-1:0]    t_z;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [CFG_W-1:0]  t_cfg;
    typedef logic [COORD_W-1:0]       t_coord;

    typedef struct packed {
        t_prod xx;
        t_prod yy;
        t_prod xy;
    } t_sqr_prod;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ORIGIN_RE = 2'd0;
    localparam t_cfg_idx CFG_ORIGIN_IM = 2'd1;
    localparam t_cfg_idx CFG_STEP_RE   = 2'd2;
    localparam t_cfg_idx CFG_STEP_IM   = 2'd3;

    localparam t_cfg RST_ORIGIN = -32'sd268435456;
    localparam t_cfg RST_STEP   = 32'sd2097152;

    localparam t_coord MAX_ITER = 8'd255;

    localparam t_z Z_MAX = {1'b0, {(Z_W-1){1'b1}}};
    localparam t_z Z_MIN = {1'b1, {(Z_W-1){1'b0}}};
    localparam t_z TWO_Q  = 36'sd536870912;
    localparam t_z NTWO_Q = -36'sd536870912;
    localparam logic signed [Z_W:0] FOUR_Q = 37'sd1073741824;

    function automatic t_z sat36(input logic signed [39:0] v);
        t_z r;
        if (v > 40'(Z_MAX)) begin
            r = Z_MAX;
        end else if (v < 40'(Z_MIN)) begin
            r = Z_MIN;
        end else begin
            r = v[Z_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/mbe_pix_if.sv
// Pixel request channel: valid/ready with column and row.
`default_nettype none
interface mbe_pix_if;
    logic             valid;
    logic             ready;
    mbe_pkg::t_coord  pixel_col;
    mbe_pkg::t_coord  pixel_row;

    modport source (output valid, output pixel_col, output pixel_row, input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/mbe_res_if.sv
// Result channel: valid/ready with echoed coordinates and escape count.
`default_nettype none
interface mbe_res_if;
    logic             valid;
    logic             ready;
    mbe_pkg::t_coord  out_col;
    mbe_pkg::t_coord  out_row;
    mbe_pkg::t_coord  escape_count;

    modport source (output valid, output out_col, output out_row, output escape_count,
                    input ready);
    modport sink   (input valid, input out_col, input out_row, input escape_count,
                    output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/mbe_sqr_unit.sv
// Shared multiplier unit: step products at setup, complex square terms otherwise.
`default_nettype none
module mbe_sqr_unit (
    input  wire logic               i_clk,
    input  wire logic               i_setup,
    input  wire mbe_pkg::t_cfg      i_x,
    input  wire mbe_pkg::t_cfg      i_y,
    input  wire mbe_pkg::t_cfg      i_step_re,
    input  wire mbe_pkg::t_cfg      i_step_im,
    input  wire mbe_pkg::t_coord    i_col,
    input  wire mbe_pkg::t_coord    i_row,
    output mbe_pkg::t_sqr_prod      o_prod
);

    mbe_pkg::t_cfg     w_a0;
    mbe_pkg::t_cfg     w_b0;
    mbe_pkg::t_cfg     w_a1;
    mbe_pkg::t_cfg     w_b1;
    mbe_pkg::t_sqr_prod r_prod;

    always_comb begin
        if (i_setup) begin
            w_a0 = i_step_re;
            w_b0 = $signed({24'd0, i_col});
            w_a1 = i_step_im;
            w_b1 = $signed({24'd0, i_row});
        end else begin
            w_a0 = i_x;
            w_b0 = i_x;
            w_a1 = i_y;
            w_b1 = i_y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod.xx <= 64'(w_a0) * 64'(w_b0);
        r_prod.yy <= 64'(w_a1) * 64'(w_b1);
        r_prod.xy <= 64'(i_x) * 64'(i_y);
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

FILE: hw/rtl/mandelbrot_escape_time_core.sv
// Escape-time evaluator top level: config registers, sequencer and result register.
// One pixel request at a time. After acceptance the core forms c (step products in
// SETUP, then origin add in CINIT), then runs each iteration of z = z*z + c as MUL, in the
// shared multiplier unit, with the large-component and cap tests, and ADD, for the
// magnitude test and update. The escape count is capped at 255 for a bounded point;
// the multiplier unit, used once per iteration, sets the pace of the loop. Request
// ready is high only while the core is idle; a finished result waits in the output
// register and the next request is taken while it is still pending.
`default_nettype none
module mandelbrot_escape_time_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire mbe_pkg::t_cfg_idx    i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data,
    mbe_pix_if.sink                   i_pix,
    mbe_res_if.source                 o_res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_CINIT = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] r_state, n_state;

    mbe_pkg::t_cfg   r_org_re, r_org_im, r_step_re, r_step_im;
    mbe_pkg::t_coord r_col, n_col, r_row, n_row;
    mbe_pkg::t_coord r_iter, n_iter;
    mbe_pkg::t_z     r_x, n_x, r_y, n_y, r_cre, n_cre, r_cim, n_cim;

    logic            r_out_valid, n_out_valid;
    mbe_pkg::t_coord r_out_col, n_out_col, r_out_row, n_out_row, r_out_cnt, n_out_cnt;

    mbe_pkg::t_sqr_prod w_prod;
    mbe_pkg::t_z        w_x2, w_y2, w_xy2;
    logic signed [mbe_pkg::Z_W:0] w_mag;
    logic               w_big;
    logic               w_accept;

    mbe_sqr_unit u_sqr (
        .i_clk     (i_clk),
        .i_setup   (r_state == ST_SETUP),
        .i_x       (r_x[31:0]),
        .i_y       (r_y[31:0]),
        .i_step_re (r_step_re),
        .i_step_im (r_step_im),
        .i_col     (r_col),
        .i_row     (r_row),
        .o_prod    (w_prod)
    );

    assign i_pix.ready = (r_state == ST_IDLE);
    assign w_accept    = i_pix.valid && (r_state == ST_IDLE);

    assign w_x2  = 36'($signed(w_prod.xx) >>> mbe_pkg::FRAC);
    assign w_y2  = 36'($signed(w_prod.yy) >>> mbe_pkg::FRAC);
    assign w_xy2 = 36'($signed(w_prod.xy) >>> (mbe_pkg::FRAC - 1));
    assign w_mag = 37'(w_x2) + 37'(w_y2);
    assign w_big = (r_x >= mbe_pkg::TWO_Q) || (r_x <= mbe_pkg::NTWO_Q)
                || (r_y >= mbe_pkg::TWO_Q) || (r_y <= mbe_pkg::NTWO_Q);

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_iter      = r_iter;
        n_x         = r_x;
        n_y         = r_y;
        n_cre       = r_cre;
        n_cim       = r_cim;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_out_cnt   = r_out_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_col   = i_pix.pixel_col;
                    n_row   = i_pix.pixel_row;
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = ST_CINIT;
            end
            ST_CINIT: begin
                n_cre   = mbe_pkg::sat36(40'(r_org_re) + 40'($signed(w_prod.xx)));
                n_cim   = mbe_pkg::sat36(40'(r_org_im) + 40'($signed(w_prod.yy)));
                n_x     = '0;
                n_y     = '0;
                n_iter  = '0;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_iter == mbe_pkg::MAX_ITER || w_big) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (w_mag >= mbe_pkg::FOUR_Q) begin
                    n_state = ST_DONE;
                end else begin
                    n_x     = mbe_pkg::sat36(40'(w_x2) - 40'(w_y2) + 40'(r_cre));
                    n_y     = mbe_pkg::sat36(40'(w_xy2) + 40'(r_cim));
                    n_iter  = r_iter + 8'd1;
                    n_state = ST_MUL;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_col   = r_col;
                    n_out_row   = r_row;
                    n_out_cnt   = r_iter;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_org_re    <= mbe_pkg::RST_ORIGIN;
            r_org_im    <= mbe_pkg::RST_ORIGIN;
            r_step_re   <= mbe_pkg::RST_STEP;
            r_step_im   <= mbe_pkg::RST_STEP;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mbe_pkg::CFG_ORIGIN_RE: r_org_re  <= i_cfg_data;
                    mbe_pkg::CFG_ORIGIN_IM: r_org_im  <= i_cfg_data;
                    mbe_pkg::CFG_STEP_RE:   r_step_re <= i_cfg_data;
                    mbe_pkg::CFG_STEP_IM:   r_step_im <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_col     <= n_col;
        r_row     <= n_row;
        r_iter    <= n_iter;
        r_x       <= n_x;
        r_y       <= n_y;
        r_cre     <= n_cre;
        r_cim     <= n_cim;
        r_out_col <= n_out_col;
        r_out_row <= n_out_row;
        r_out_cnt <= n_out_cnt;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.out_col      = r_out_col;
    assign o_res.out_row      = r_out_row;
    assign o_res.escape_count = r_out_cnt;

    // one pixel in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_pix.ready)
        else $error("request taken while busy");

    a_add_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ADD |-> $past(r_state) == ST_MUL)
        else $error("update without products");

    a_first_iter_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL && r_iter == 8'd0) |-> (r_x == '0 && r_y == '0))
        else $error("z not cleared at start");

endmodule
`default_nettype wire

FILE: tb/tb_mandelbrot_escape_time_core.sv
// Self-checking bench for the escape-time core: directed table, then random views vs. a predictor.
`default_nettype none
module tb_mandelbrot_escape_time_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     HALF_PERIOD = 6;
    localparam int     RST_CYCLES  = 11;
    localparam longint CYCLE_LIMIT = 3_000_000;
    localparam int     PHASES      = 6;
    localparam int     PHASE_ITEMS = 189;
    localparam int     SETTLE      = 600;
    localparam int     ITER_CAP    = 255;
    localparam longint ZHI         = (64'sd1 <<< 35) - 1;
    localparam longint ZLO         = -(64'sd1 <<< 35);
    localparam longint RADIUS      = 64'sd1 <<< 29;
    localparam longint NORM_LIMIT  = 64'sd1 <<< 30;

    typedef struct packed {
        logic              is_cfg;
        mbe_pkg::t_cfg_idx idx;
        logic [31:0]       data;
        mbe_pkg::t_coord   col;
        mbe_pkg::t_coord   row;
        logic              typed;
        mbe_pkg::t_coord   count;
    } t_plan_row;

    typedef struct {
        mbe_pkg::t_coord col;
        mbe_pkg::t_coord row;
        mbe_pkg::t_coord count;
    } t_escape;

    localparam int PLAN_ROWS = 34;
    localparam t_plan_row PLAN [PLAN_ROWS] = '{
        '{1'b0, mbe_pkg::CFG_ORIGIN_RE, 32'h0,         8'd128, 8'd128, 1'b1, 8'd255},
        '{1'b0, mbe_pkg::CFG_ORIGIN_RE, 32'h0,         8'd0,   8'd0,   1'b0, 8'd0},
        '{1'b0, mbe_pkg::CFG_ORIGIN_RE, 32'h0,         8'd255, 8'd255, 1'b0, 8'd0},
        '{1'b0, mbe_pkg::CFG_ORIGIN_RE, 32'h0,         8'd255, 8'd0,   1'b0, 8'd0},
        '{1'b0, mbe_pkg::CFG_ORIGIN_RE, 32'h0,         8'd0,   8'd255, 1'b0, 8'd0},
        '{1'b0, mbe_pkg::CFG_ORIGIN_RE, 32'h0,         8'd64,  8'd128, 1'b0, 8'd0},
        '{1'b0, mbe_pkg::CFG_ORIGIN_RE, 32'h0,         8'd96,  8'd192, 1'b0, 8'd0},
        '{1'b1, mbe_pkg::CFG_ORIGIN_RE, 32'h7FFF_FFFF, 8'd0,   8'd0,   1'b0, 8'd0},
        '{1'b0, mbe_pkg::CFG_ORIGIN_RE, 32'h0,         8'd0,   8'd0,   1'b1, 8'd1},
        '{1'b0, mbe_pkg::CFG_ORIGIN_RE, 32'h0,         8'd255, 8'd255, 1'b1, 8'd1},
        '{1'b1, mbe_pkg::CFG_ORIGIN_RE, 32'h8000_0000, 8'd0,   8'd0,   1'b0, 8'd0},
        '{1'b1, mbe_pkg::CFG_ORIGIN_IM, 32'h8000_0000, 8'd0,   8'd0,   1'b0, 8'd0},
        '{1'b1, mbe_pkg::CFG_STEP_RE,   32'h7FFF_FFFF, 8'd0,   8'd0,   1'b0, 8'd0},
        '{1'b1, mbe_pkg::CFG_STEP_IM,   32'h7FFF_FFFF, 8'd0,   8'd0,   1'b0, 8'd0},
        '{1'b0, mbe_pkg::CFG_ORIGIN_RE, 32'h0,         8'd0,   8'd0,   1'b1, 8'd1},
        '{1'b0, mbe_pkg::CFG_ORIGIN_RE, 32'h0,         8'd255, 8'd255, 1'b1, 8'd1},
        '{1'b0, mbe_pkg::CFG_ORIGIN_RE, 32'h0,         8'd1,   8'd1,   1'b0, 8'd0},
        '{1'b1, mbe_pkg::CFG_STEP_RE,   32'h8000_0000, 8'd0,   8'd0,   1'b0, 8'd0},
        '{1'b1, mbe_pkg::CFG_STEP_IM,   32'h8000_0000, 8'd0,   8'd0,   1'b0, 8'd0},
        '{1'b0, mbe_pkg::CFG_ORIGIN_RE, 32'h0,         8'd255, 8'd255, 1'b1, 8'd1},
        '{1'b0, mbe_pkg::CFG_ORIGIN_RE, 32'h0,         8'd0,   8'd255, 1'b1, 8'd1},
        '{1'b1, mbe_pkg::CFG_ORIGIN_RE, 32'h0,         8'd0,   8'd0,   1'b0, 8'd0},
        '{1'b1, mbe_pkg::CFG_ORIGIN_IM, 32'h0,         8'd0,   8'd0,   1'b0, 8'd0},
        '{1'b1, mbe_pkg::CFG_STEP_RE,   32'h0,         8'd0,   8'd0,   1'b0, 8'd0},
        '{1'b1, mbe_pkg::CFG_STEP_IM,   32'h0,         8'd0,   8'd0,   1'b0, 8'd0},
        '{1'b0, mbe_pkg::CFG_ORIGIN_RE, 32'h0,         8'd255, 8'd255, 1'b1, 8'd255},
        '{1'b0, mbe_pkg::CFG_ORIGIN_RE, 32'h0,         8'd170, 8'd85,  1'b1, 8'd255},
        // c = -2 exactly: the large-component test fires after one update
        '{1'b1, mbe_pkg::CFG_ORIGIN_RE, 32'hE000_0000, 8'd0,   8'd0,   1'b0, 8'd0},
        '{1'b0, mbe_pkg::CFG_ORIGIN_RE, 32'h0,         8'd85,  8'd170, 1'b1, 8'd1},
        '{1'b1, mbe_pkg::CFG_ORIGIN_RE, 32'h0400_0000, 8'd0,   8'd0,   1'b0, 8'd0},
        '{1'b0, mbe_pkg::CFG_ORIGIN_RE, 32'h0,         8'd0,   8'd0,   1'b0, 8'd0},
        '{1'b1, mbe_pkg::CFG_ORIGIN_RE, 32'h0000_0000, 8'd0,   8'd0,   1'b0, 8'd0},
        '{1'b1, mbe_pkg::CFG_ORIGIN_IM, 32'h1FFF_FFFF, 8'd0,   8'd0,   1'b0, 8'd0},
        '{1'b0, mbe_pkg::CFG_ORIGIN_RE, 32'h0,         8'd3,   8'd3,   1'b0, 8'd0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    mbe_pkg::t_cfg_idx i_cfg_idx = mbe_pkg::CFG_ORIGIN_RE;
    logic [31:0]       i_cfg_data = '0;

    mbe_pix_if pix_ch();
    mbe_res_if res_ch();

    mandelbrot_escape_time_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_ch),
        .o_res      (res_ch)
    );

    mbe_pkg::t_cfg view_origin_re = 32'shF000_0000;
    mbe_pkg::t_cfg view_origin_im = 32'shF000_0000;
    mbe_pkg::t_cfg view_step_re   = 32'sd2097152;
    mbe_pkg::t_cfg view_step_im   = 32'sd2097152;
    t_escape       awaited_escapes[$];
    int            mismatch_count = 0;
    longint        cycles = 0;
    bit            calm = 1'b0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic longint clamp_z(longint v);
        if (v > ZHI) begin
            return ZHI;
        end
        if (v < ZLO) begin
            return ZLO;
        end
        return v;
    endfunction

    function automatic mbe_pkg::t_coord predict_escape(mbe_pkg::t_coord col,
                                                       mbe_pkg::t_coord row);
        longint cre, cim, x, y, xx, yy, xy;
        int k;
        cre = clamp_z(longint'(view_origin_re) + longint'(view_step_re) * longint'(col));
        cim = clamp_z(longint'(view_origin_im) + longint'(view_step_im) * longint'(row));
        x = 0;
        y = 0;
        for (k = 0; k < ITER_CAP; k++) begin
            if (x >= RADIUS || x <= -RADIUS || y >= RADIUS || y <= -RADIUS) begin
                break;
            end
            xx = (x * x) >>> mbe_pkg::FRAC;
            yy = (y * y) >>> mbe_pkg::FRAC;
            if (xx + yy >= NORM_LIMIT) begin
                break;
            end
            xy = (x * y) >>> (mbe_pkg::FRAC - 1);
            x = clamp_z(xx - yy + cre);
            y = clamp_z(xy + cim);
        end
        return mbe_pkg::t_coord'(k);
    endfunction

    task automatic note_mismatch(string what, t_escape want, int got, int exp_val);
        $display("ERROR %0t: pixel (%0d,%0d) %s got %0d want %0d",
                 $realtime, want.col, want.row, what, got, exp_val);
        mismatch_count++;
    endtask

    // pixel request; valid stays high on return so back-to-back requests need no re-raise
    task automatic send_pixel(mbe_pkg::t_coord col, mbe_pkg::t_coord row, logic typed,
                              mbe_pkg::t_coord typed_count);
        t_escape e;
        if (i_cfg_we) begin
            i_cfg_we <= 1'b0;
        end
        if (!calm && $urandom_range(0, 99) < 16) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.pixel_col <= col;
        pix_ch.pixel_row <= row;
        do @(posedge i_clk); while (!pix_ch.ready);
        e.col   = col;
        e.row   = row;
        e.count = typed ? typed_count : predict_escape(col, row);
        awaited_escapes.push_back(e);
    endtask

    task automatic drain();
        pix_ch.valid <= 1'b0;
        while (awaited_escapes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(mbe_pkg::t_cfg_idx idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            mbe_pkg::CFG_ORIGIN_RE: view_origin_re = data;
            mbe_pkg::CFG_ORIGIN_IM: view_origin_im = data;
            mbe_pkg::CFG_STEP_RE:   view_step_re   = data;
            mbe_pkg::CFG_STEP_IM:   view_step_im   = data;
            default: ;
        endcase
    endtask

    task automatic load_view(mbe_pkg::t_cfg re0, mbe_pkg::t_cfg im0, mbe_pkg::t_cfg dre,
                             mbe_pkg::t_cfg dim);
        write_reg(mbe_pkg::CFG_ORIGIN_RE, re0);
        write_reg(mbe_pkg::CFG_ORIGIN_IM, im0);
        write_reg(mbe_pkg::CFG_STEP_RE, dre);
        write_reg(mbe_pkg::CFG_STEP_IM, dim);
    endtask

    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= calm || ($urandom_range(0, 99) >= 16);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_escape want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (awaited_escapes.size() == 0) begin
                want.col   = res_ch.out_col;
                want.row   = res_ch.out_row;
                want.count = res_ch.escape_count;
                note_mismatch("unexpected result, count", want, res_ch.escape_count, -1);
            end else begin
                want = awaited_escapes.pop_front();
                if (res_ch.out_col !== want.col) begin
                    note_mismatch("out_col", want, res_ch.out_col, want.col);
                end
                if (res_ch.out_row !== want.row) begin
                    note_mismatch("out_row", want, res_ch.out_row, want.row);
                end
                if (res_ch.escape_count !== want.count) begin
                    note_mismatch("escape_count", want, res_ch.escape_count, want.count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        t_plan_row     r;
        mbe_pkg::t_cfg re0, im0, dre, dim;
        int            phase, n;
        pix_ch.valid     = 1'b0;
        pix_ch.pixel_col = '0;
        pix_ch.pixel_row = '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < PLAN_ROWS; n++) begin
            r = PLAN[n];
            if (r.is_cfg) begin
                drain();
                write_reg(r.idx, r.data);
            end else begin
                send_pixel(r.col, r.row, r.typed, r.count);
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            calm = (phase == 2);
            if (phase == 4) begin
                load_view($urandom(), $urandom(), $urandom(), $urandom());
            end else if (phase == 0) begin
                load_view(32'shF000_0000, 32'shF000_0000, 32'sd2097152, 32'sd2097152);
            end else begin
                // mostly around the interesting part of the plane
                re0 = -32'sd603979776 + mbe_pkg::t_cfg'($urandom_range(0, 738197504));
                im0 = -32'sd335544320 + mbe_pkg::t_cfg'($urandom_range(0, 402653184));
                dre = mbe_pkg::t_cfg'($urandom_range(4096, 2097152));
                dim = mbe_pkg::t_cfg'($urandom_range(4096, 2097152));
                if ($urandom_range(0, 3) == 0) begin
                    dre = -dre;
                end
                if ($urandom_range(0, 3) == 0) begin
                    dim = -dim;
                end
                load_view(re0, im0, dre, dim);
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n == 40) begin
                    drain();
                end
                send_pixel(mbe_pkg::t_coord'($urandom_range(0, 255)),
                           mbe_pkg::t_coord'($urandom_range(0, 255)), 1'b0, '0);
            end
        end

        calm = 1'b0;
        drain();
        i_cfg_we <= 1'b0;
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_escapes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire
